### rtl/sahe_pkg.sv
// Package for the selective acknowledgment history encoder.
// Holds payload structs, the controller state type and shared constants.
// No dependencies.
package sahe_pkg;

   localparam int HISTORY_BITS_DEF = 256;
   localparam int PAIR_LIMIT_DEF   = 16;
   localparam int WORD_BITS        = 64;
   localparam int OUT_CAP          = 16;
   localparam logic [7:0] RUN_MAX  = 8'd255;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] pkt_seq;
      logic [5:0]  block_limit;
      logic [9:0]  report_cap;
   } req_type;

   typedef struct packed {
      logic [15:0] ack_seq;
      logic        block_valid;
      logic [3:0]  block_index;
      logic [7:0]  acked_run;
      logic [7:0]  missing_run;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SH_PRIME,
      ST_SH_UPPER,
      ST_SH_STEP,
      ST_OLD_RD,
      ST_OLD_WR,
      ST_RP_LOAD,
      ST_RP_CAP,
      ST_RP_BIT,
      ST_EM_READ,
      ST_EM_PUT,
      ST_EM_EMPTY
   } state_type;

endpackage

### rtl/sahe_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Used for the history bitmap and the run pair buffer. No dependencies.
module sahe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/selective_ack_history_encoder_unit.sv
// Selective acknowledgment history encoder: keeps a bitmap of received packets
// relative to the highest sequence seen and run-length encodes it on request.
// Depends on sahe_pkg and sahe_ram.
//
// One item is processed at a time; req_ready is high only while the block is
// idle. A duplicate or an out-of-window packet is dropped in the idle state,
// an older packet inside the window does a read-modify-write of one history
// word, and a newer or first packet runs a word-by-word shift sweep through
// the history RAM. A report walks one history bit per cycle, with extra
// steps at each run boundary and for each history word fetched, then reads
// the pair buffer RAM once per result, plus any stall on rsp_ready.
// The history RAM needs no clearing after reset: the first record rewrites
// every word.
module selective_ack_history_encoder_unit
   import sahe_pkg::*;
#(
   parameter int HISTORY_BITS = HISTORY_BITS_DEF,
   parameter int PAIR_LIMIT   = PAIR_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NW       = (HISTORY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int IDXW     = NW > 1 ? $clog2(NW) : 1;
   localparam int SW       = IDXW + 2;
   localparam int BW       = $clog2(HISTORY_BITS + 1);
   localparam int LW       = BW > 10 ? BW : 10;
   localparam int WANT_CAP = PAIR_LIMIT < OUT_CAP ? PAIR_LIMIT : OUT_CAP;

   state_type               state_ff, state_in;
   logic                    seen_ff, seen_in;
   logic [15:0]             highest_ff, highest_in;
   logic [BW-1:0]           valid_cnt_ff, valid_cnt_in;
   logic [IDXW:0]           words_ff, words_in;
   logic [5:0]              rem_ff, rem_in;
   logic signed [SW-1:0]    src_ff, src_in;
   logic [IDXW-1:0]         dst_ff, dst_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [WORD_BITS-1:0]    upper_ff, upper_in;
   logic [BW-1:0]           back_ff, back_in;
   logic [BW-1:0]           b_ff, b_in;
   logic [BW-1:0]           limit_ff, limit_in;
   logic [4:0]              want_ff, want_in;
   logic [4:0]              count_ff, count_in;
   logic [4:0]              keep_ff, keep_in;
   logic [4:0]              k_ff, k_in;
   logic [7:0]              acks_ff, acks_in;
   logic [7:0]              nacks_ff, nacks_in;
   logic                    phase_ff, phase_in;
   logic [WORD_BITS-1:0]    word_ff, word_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    h_we, h_re;
   logic [IDXW-1:0]         h_waddr, h_raddr;
   logic [WORD_BITS-1:0]    h_wdata, h_rdata;
   logic                    p_we, p_re;
   logic [3:0]              p_waddr, p_raddr;
   logic [15:0]             p_wdata, p_rdata;

   logic                    slot_free;
   logic [15:0]             diff, back_full;
   logic [16:0]             vsum;
   logic [WORD_BITS-1:0]    lower, shval;
   logic signed [SW-1:0]    s0;
   logic [4:0]              want_c, count_n, keep_n;
   logic [LW-1:0]           vc_ext, cap_ext;
   logic                    cur_bit;
   logic [BW-1:0]           b_next;

   sahe_ram #(.WIDTH(WORD_BITS), .DEPTH(NW)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   sahe_ram #(.WIDTH(16), .DEPTH(OUT_CAP)) u_pair_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         highest_ff   <= '0;
         valid_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         highest_ff   <= highest_in;
         valid_cnt_ff <= valid_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      words_ff <= words_in;
      rem_ff   <= rem_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      rd_ok_ff <= rd_ok_in;
      upper_ff <= upper_in;
      back_ff  <= back_in;
      b_ff     <= b_in;
      limit_ff <= limit_in;
      want_ff  <= want_in;
      count_ff <= count_in;
      keep_ff  <= keep_in;
      k_ff     <= k_in;
      acks_ff  <= acks_in;
      nacks_ff <= nacks_in;
      phase_ff <= phase_in;
      word_ff  <= word_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      highest_in   = highest_ff;
      valid_cnt_in = valid_cnt_ff;
      words_in     = words_ff;
      rem_in       = rem_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rd_ok_in     = rd_ok_ff;
      upper_in     = upper_ff;
      back_in      = back_ff;
      b_in         = b_ff;
      limit_in     = limit_ff;
      want_in      = want_ff;
      count_in     = count_ff;
      keep_in      = keep_ff;
      k_in         = k_ff;
      acks_in      = acks_ff;
      nacks_in     = nacks_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      h_we    = 1'b0;
      h_waddr = dst_ff;
      h_wdata = '0;
      h_re    = 1'b0;
      h_raddr = src_ff[IDXW-1:0];
      p_we    = 1'b0;
      p_waddr = count_ff[3:0];
      p_wdata = {acks_ff, nacks_ff};
      p_re    = 1'b0;
      p_raddr = k_ff[3:0];

      diff      = req_data.pkt_seq - highest_ff;
      back_full = highest_ff - req_data.pkt_seq;
      vsum      = 17'(valid_cnt_ff) + 17'(diff);
      want_c    = (32'(req_data.block_limit) > WANT_CAP) ? 5'(WANT_CAP)
                                                         : 5'(req_data.block_limit);
      vc_ext    = LW'(valid_cnt_ff);
      cap_ext   = LW'(req_data.report_cap);
      s0        = SW'(NW - 1) - SW'(words_ff);
      lower     = rd_ok_ff ? h_rdata : '0;
      shval     = upper_ff << rem_ff;
      if (rem_ff != 6'd0) begin
         shval = shval | (lower >> (7'd64 - {1'b0, rem_ff}));
      end
      cur_bit   = word_ff[b_ff[5:0]];
      b_next    = b_ff + BW'(1);
      count_n   = count_ff + 5'd1;
      keep_n    = (acks_ff != 8'd0) ? count_n : keep_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_RECORD) begin
                  if (!seen_ff) begin
                     // first packet: clear every word and set bit 0
                     seen_in      = 1'b1;
                     highest_in   = req_data.pkt_seq;
                     valid_cnt_in = BW'(1);
                     words_in     = (IDXW+1)'(NW);
                     rem_in       = 6'd0;
                     state_in     = ST_SH_PRIME;
                  end else if (diff != 16'd0) begin
                     if (!diff[15]) begin
                        highest_in   = req_data.pkt_seq;
                        valid_cnt_in = (vsum > 17'(HISTORY_BITS)) ? BW'(HISTORY_BITS)
                                                                  : BW'(vsum);
                        words_in     = (32'(diff) >= HISTORY_BITS) ? (IDXW+1)'(NW)
                                                                   : (IDXW+1)'(diff >> 6);
                        rem_in       = diff[5:0];
                        state_in     = ST_SH_PRIME;
                     end else if (32'(back_full) < HISTORY_BITS) begin
                        back_in  = BW'(back_full);
                        state_in = ST_OLD_RD;
                     end
                  end
               end else begin
                  want_in  = want_c;
                  limit_in = (vc_ext < cap_ext) ? valid_cnt_ff : BW'(cap_ext);
                  b_in     = '0;
                  count_in = '0;
                  keep_in  = '0;
                  acks_in  = '0;
                  nacks_in = '0;
                  phase_in = 1'b0;
                  if (!seen_ff || want_c == 5'd0 || req_data.report_cap == 10'd0 ||
                      valid_cnt_ff == '0) begin
                     state_in = ST_EM_EMPTY;
                  end else begin
                     state_in = ST_RP_LOAD;
                  end
               end
            end
         end
         ST_SH_PRIME: begin
            h_re     = 1'b1;
            h_raddr  = s0[IDXW-1:0];
            rd_ok_in = (s0 >= 0);
            src_in   = s0 - SW'(1);
            dst_in   = IDXW'(NW - 1);
            state_in = ST_SH_UPPER;
         end
         ST_SH_UPPER: begin
            upper_in = lower;
            h_re     = 1'b1;
            rd_ok_in = (src_ff >= 0);
            src_in   = src_ff - SW'(1);
            state_in = ST_SH_STEP;
         end
         ST_SH_STEP: begin
            // write one destination word, stream the next lower source word
            h_we     = 1'b1;
            h_wdata  = (dst_ff == '0) ? (shval | WORD_BITS'(1)) : shval;
            upper_in = lower;
            h_re     = 1'b1;
            rd_ok_in = (src_ff >= 0);
            src_in   = src_ff - SW'(1);
            dst_in   = dst_ff - IDXW'(1);
            if (dst_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_OLD_RD: begin
            h_re     = 1'b1;
            h_raddr  = IDXW'(back_ff >> 6);
            state_in = ST_OLD_WR;
         end
         ST_OLD_WR: begin
            h_we     = 1'b1;
            h_waddr  = IDXW'(back_ff >> 6);
            h_wdata  = h_rdata | (WORD_BITS'(1) << back_ff[5:0]);
            state_in = ST_IDLE;
         end
         ST_RP_LOAD: begin
            h_re     = 1'b1;
            h_raddr  = IDXW'(b_ff >> 6);
            state_in = ST_RP_CAP;
         end
         ST_RP_CAP: begin
            word_in  = h_rdata;
            state_in = ST_RP_BIT;
         end
         ST_RP_BIT: begin
            if (!phase_ff) begin
               if (b_ff < limit_ff && acks_ff != RUN_MAX && cur_bit) begin
                  acks_in = acks_ff + 8'd1;
                  b_in    = b_next;
                  if (b_next[5:0] == 6'd0) begin
                     state_in = ST_RP_LOAD;
                  end
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               if (b_ff < limit_ff && nacks_ff != RUN_MAX && !cur_bit) begin
                  nacks_in = nacks_ff + 8'd1;
                  b_in     = b_next;
                  if (b_next[5:0] == 6'd0) begin
                     state_in = ST_RP_LOAD;
                  end
               end else begin
                  // close the pair; keep tracks the last pair with acks
                  p_we     = 1'b1;
                  count_in = count_n;
                  keep_in  = keep_n;
                  acks_in  = '0;
                  nacks_in = '0;
                  phase_in = 1'b0;
                  if (!(b_ff < limit_ff && count_n < want_ff)) begin
                     k_in     = '0;
                     state_in = (keep_n == 5'd0) ? ST_EM_EMPTY : ST_EM_READ;
                  end
               end
            end
         end
         ST_EM_READ: begin
            p_re     = 1'b1;
            state_in = ST_EM_PUT;
         end
         ST_EM_PUT: begin
            if (slot_free) begin
               rsp_in.ack_seq     = highest_ff;
               rsp_in.block_valid = 1'b1;
               rsp_in.block_index = k_ff[3:0];
               rsp_in.acked_run   = p_rdata[15:8];
               rsp_in.missing_run = p_rdata[7:0];
               rsp_in.last        = (k_ff + 5'd1 == keep_ff);
               rsp_valid_in       = 1'b1;
               k_in               = k_ff + 5'd1;
               state_in           = (k_ff + 5'd1 == keep_ff) ? ST_IDLE : ST_EM_READ;
            end
         end
         ST_EM_EMPTY: begin
            if (slot_free) begin
               rsp_in.ack_seq     = highest_ff;
               rsp_in.block_valid = 1'b0;
               rsp_in.block_index = '0;
               rsp_in.acked_run   = '0;
               rsp_in.missing_run = '0;
               rsp_in.last        = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_valid_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      32'(valid_cnt_ff) <= HISTORY_BITS)
      else $error("valid count above history size");

   a_unseen_empty: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> valid_cnt_ff == '0)
      else $error("valid count nonzero before first packet");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EM_PUT |-> (k_ff < keep_ff && keep_ff <= 5'(OUT_CAP)))
      else $error("pair emit index out of range");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_STEP && src_ff >= 0) |-> h_raddr != h_waddr)
      else $error("shift sweep reads the word it writes");

endmodule

### bench/tb_selective_ack_history_encoder_unit.sv
// Testbench for selective_ack_history_encoder_unit: drives record and report beats,
// predicts the ack/nack run pairs of each report and checks every result beat.
// Depends on sahe_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_selective_ack_history_encoder_unit;
   import sahe_pkg::*;

   localparam int HBITS = HISTORY_BITS_DEF;
   localparam int MAXB  = PAIR_LIMIT_DEF;
   localparam int HIDXW = $clog2(HBITS);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   selective_ack_history_encoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // predictor state
   bit              have_seen;
   bit [15:0]       top_seq;
   bit [HBITS-1:0]  rx_map;
   int              rx_count;

   req_type pending_beats[$];
   rsp_type expected_acks[$];
   int      mismatches = 0;

   function automatic void apply_arrival(bit [15:0] seq);
      bit [15:0] seq_delta;
      bit [15:0] back;
      if (!have_seen) begin
         have_seen = 1'b1;
         top_seq = seq;
         rx_map = '0;
         rx_map[0] = 1'b1;
         rx_count = 1;
         return;
      end
      seq_delta = seq - top_seq;
      if (seq_delta == 0) return;
      if (seq_delta < 16'h8000) begin
         rx_map = (int'(seq_delta) >= HBITS) ? '0 : (rx_map << seq_delta);
         rx_map[0] = 1'b1;
         top_seq = seq;
         rx_count = rx_count + int'(seq_delta);
         if (rx_count > HBITS) rx_count = HBITS;
      end else begin
         back = top_seq - seq;
         if (int'(back) < HBITS) rx_map[back[HIDXW-1:0]] = 1'b1;
      end
   endfunction

   function automatic void predict_report(int want, int cap);
      int acks[16];
      int nacks[16];
      int cnt, lim, b, a, n;
      rsp_type r;
      cnt = 0;
      b = 0;
      if (want > MAXB) want = MAXB;
      if (want > 16) want = 16;
      if (have_seen && want != 0) begin
         lim = (rx_count > cap) ? cap : rx_count;
         while (b < lim && cnt < want) begin
            a = 0;
            n = 0;
            while (b < lim && a < 255 && rx_map[b]) begin a++; b++; end
            while (b < lim && n < 255 && !rx_map[b]) begin n++; b++; end
            if (a == 0 && n == 0) break;
            acks[cnt] = a;
            nacks[cnt] = n;
            cnt++;
         end
         while (cnt > 0 && acks[cnt-1] == 0) cnt--;
      end
      if (cnt == 0) begin
         r = '0;
         r.ack_seq = top_seq;
         r.last = 1'b1;
         expected_acks.push_back(r);
         return;
      end
      for (int k = 0; k < cnt; k++) begin
         r.ack_seq = top_seq;
         r.block_valid = 1'b1;
         r.block_index = k[3:0];
         r.acked_run = acks[k][7:0];
         r.missing_run = nacks[k][7:0];
         r.last = (k + 1 == cnt);
         expected_acks.push_back(r);
      end
   endfunction

   // sender: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_RECORD) apply_arrival(req_data.pkt_seq);
            else predict_report(int'(req_data.block_limit), int'(req_data.report_cap));
         end
         if (req_valid && !req_ready) begin
            // hold beat
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern of its own
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         if ((stall_phase / 64) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
         if (rsp_valid && rsp_ready) begin
            if (expected_acks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_acks.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %p got %p", e, rsp_data);
               end
            end
         end
      end
   end

   function automatic req_type mk_rec(bit [15:0] seq);
      req_type q;
      q = '0;
      q.opcode = OP_RECORD;
      q.pkt_seq = seq;
      q.block_limit = 6'($urandom());
      q.report_cap = 10'($urandom());
      return q;
   endfunction

   function automatic req_type mk_rep(bit [5:0] lim, bit [9:0] cap);
      req_type q;
      q.opcode = OP_REPORT;
      q.pkt_seq = 16'($urandom());
      q.block_limit = lim;
      q.report_cap = cap;
      return q;
   endfunction

   initial begin
      bit [15:0] base;
      int r;
      // directed: empty report before anything, first record, extremes
      pending_beats.push_back(mk_rep(6'd63, 10'd1023));
      pending_beats.push_back(mk_rec(16'hFFFF));
      pending_beats.push_back(mk_rep(6'd63, 10'd1023));
      pending_beats.push_back(mk_rec(16'hFFFF));           // duplicate
      pending_beats.push_back(mk_rec(16'h0002));           // newer across wrap
      pending_beats.push_back(mk_rec(16'h0000));           // older in window
      pending_beats.push_back(mk_rec(16'h8002));           // distance 32768
      pending_beats.push_back(mk_rep(6'd0, 10'd1023));     // zero limit
      pending_beats.push_back(mk_rep(6'd16, 10'd0));       // zero cap
      pending_beats.push_back(mk_rep(6'd1, 10'd2));
      pending_beats.push_back(mk_rec(16'h0102));           // shift 256 clears
      pending_beats.push_back(mk_rec(16'h0001));           // outside window
      pending_beats.push_back(mk_rec(16'h0190));           // shift 142
      pending_beats.push_back(mk_rec(16'h0110));
      pending_beats.push_back(mk_rec(16'h0250));           // saturate count
      pending_beats.push_back(mk_rep(6'd17, 10'd1023));
      pending_beats.push_back(mk_rec(16'h0251));
      pending_beats.push_back(mk_rep(6'd2, 10'd300));
      pending_beats.push_back(mk_rec(16'h7FFF));
      pending_beats.push_back(mk_rep(6'd63, 10'd255));
      // random: local sequence walks with loss and reordering
      base = 16'($urandom());
      for (int i = 0; i < 380; i++) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            pending_beats.push_back(mk_rep(6'($urandom_range(0, 63)),
               ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                           : 10'($urandom_range(0, 300))));
         else if (r < 55) begin
            base = base + 16'($urandom_range(1, 4));
            pending_beats.push_back(mk_rec(base));
         end else if (r < 85)
            pending_beats.push_back(mk_rec(base - 16'($urandom_range(0, 300))));
         else if (r < 92) begin
            base = base + 16'($urandom_range(1, 400));
            pending_beats.push_back(mk_rec(base));
         end else
            pending_beats.push_back(mk_rec(16'($urandom())));
      end
      pending_beats.push_back(mk_rep(6'd16, 10'd1023));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_beats.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_acks.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_acks.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
